[rtl/core/gif_container_stream_parser_top_assert.svh]
// Assertion macros used by the parser's result queue
`ifndef GIF_CONTAINER_STREAM_PARSER_TOP_ASSERT_SVH
`define GIF_CONTAINER_STREAM_PARSER_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define GCSP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication checked outside reset
`define GCSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[rtl/core/gcsp_pkg.sv]
`default_nettype none
package gcsp_pkg;

    // result kinds
    localparam logic [3:0] KIND_SCREEN   = 4'd0;
    localparam logic [3:0] KIND_GCOLOR   = 4'd1;
    localparam logic [3:0] KIND_GCTRL    = 4'd2;
    localparam logic [3:0] KIND_IMAGE    = 4'd3;
    localparam logic [3:0] KIND_LCOLOR   = 4'd4;
    localparam logic [3:0] KIND_CODESIZE = 4'd5;
    localparam logic [3:0] KIND_APPHDR   = 4'd6;
    localparam logic [3:0] KIND_PAYLOAD  = 4'd7;
    localparam logic [3:0] KIND_BLKEND   = 4'd8;
    localparam logic [3:0] KIND_DONE     = 4'd9;
    localparam logic [3:0] KIND_ERROR    = 4'd10;

    // error codes
    localparam logic [2:0] ERR_HEADER   = 3'd1;
    localparam logic [2:0] ERR_APPSIZE  = 3'd2;
    localparam logic [2:0] ERR_CTRLSIZE = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd4;
    localparam logic [2:0] ERR_TRUNC    = 3'd5;

    // block types
    localparam logic [2:0] BLK_NONE  = 3'd0;
    localparam logic [2:0] BLK_IMAGE = 3'd1;
    localparam logic [2:0] BLK_CMT   = 3'd2;
    localparam logic [2:0] BLK_TEXT  = 3'd3;
    localparam logic [2:0] BLK_APP   = 3'd4;

    // stream bytes
    localparam logic [7:0] BYTE_TRAILER = 8'h3B;
    localparam logic [7:0] BYTE_EXT     = 8'h21;
    localparam logic [7:0] BYTE_IMAGE   = 8'h2C;
    localparam logic [7:0] LBL_GCTRL    = 8'hF9;
    localparam logic [7:0] LBL_TEXT     = 8'h01;
    localparam logic [7:0] LBL_APP      = 8'hFF;
    localparam logic [7:0] LBL_CMT      = 8'hFE;
    localparam logic [7:0] APP_SIZE     = 8'd11;
    localparam logic [7:0] GCTRL_SIZE   = 8'd4;

    localparam int TDATA_W = 112;

    typedef enum logic [15:0] {
        PH_HDR      = 16'h0001,
        PH_GTAB     = 16'h0002,
        PH_BLOCK    = 16'h0004,
        PH_EXTLABEL = 16'h0008,
        PH_GCSIZE   = 16'h0010,
        PH_GCBODY   = 16'h0020,
        PH_GCTERM   = 16'h0040,
        PH_APPSIZE  = 16'h0080,
        PH_APPBODY  = 16'h0100,
        PH_IMG      = 16'h0200,
        PH_LTAB     = 16'h0400,
        PH_CODESIZE = 16'h0800,
        PH_SUBLEN   = 16'h1000,
        PH_SUBDATA  = 16'h2000,
        PH_DONE     = 16'h4000,
        PH_DEAD     = 16'h8000
    } phase_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  block_type;
        logic [15:0] field_a;
        logic [15:0] field_b;
        logic [15:0] field_c;
        logic [15:0] field_d;
        logic [8:0]  tab_entries;
        logic [3:0]  small_field;
        logic [1:0]  flag_bits;
        logic [23:0] data_value;
        logic [2:0]  error_code;
    } rec_t;

    // up to two results of one byte
    typedef struct packed {
        logic [1:0] cnt;
        rec_t       r0;
        rec_t       r1;
    } pair_t;

    function automatic rec_t rec_new(input logic [3:0] k, input logic [2:0] bt);
        rec_t r;
        r = '0;
        r.kind = k;
        r.block_type = bt;
        return r;
    endfunction

    // tdata: block_type, a, b, c, d, tab_entries, small, flags, data, error (kind goes on tuser)
    function automatic logic [TDATA_W-1:0] rec_pack(input rec_t r);
        return {3'd0, r.error_code, r.data_value, r.flag_bits, r.small_field,
                r.tab_entries, r.field_d, r.field_c, r.field_b, r.field_a,
                r.block_type};
    endfunction

endpackage
`default_nettype wire

[rtl/core/gcsp_parse.sv]
`default_nettype none
module gcsp_parse import gcsp_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] byte_in,
    input  wire logic       eos,
    output pair_t           res
);
    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [8:0]  left_reg, left_next;
    logic [1:0]  rgbs_reg, rgbs_next;
    logic [15:0] rgbp_reg, rgbp_next;
    logic [7:0]  sub_reg, sub_next;
    logic [15:0] fs_reg [4];
    logic [15:0] fs_next [4];
    logic [7:0]  ps_reg, ps_next;
    logic [23:0] ver_reg, ver_next;
    logic        cp_reg, cp_next;
    logic [2:0]  cb_reg, cb_next;

    function automatic logic [8:0] tab_total(input logic [2:0] sz);
        return 9'd2 << sz;
    endfunction

    always_comb begin
        rec_t       r;
        logic       have;
        logic [1:0] idx;
        logic [1:0] hidx;
        logic [8:0] tot;
        phase_next = phase_reg; pos_next = pos_reg; left_next = left_reg;
        rgbs_next = rgbs_reg; rgbp_next = rgbp_reg; sub_next = sub_reg;
        fs_next = fs_reg; ps_next = ps_reg; ver_next = ver_reg;
        cp_next = cp_reg; cb_next = cb_reg;
        r = '0; have = 1'b0;
        idx = pos_reg[2:1];
        hidx = {1'b0, pos_reg[3]};
        tot = tab_total(ps_reg[2:0]);
        case (phase_reg)
            PH_HDR: begin
                if (pos_reg < 4'd3) begin
                    if ((pos_reg == 4'd0 && byte_in != 8'h47) ||
                        (pos_reg == 4'd1 && byte_in != 8'h49) ||
                        (pos_reg == 4'd2 && byte_in != 8'h46)) begin
                        r = rec_new(KIND_ERROR, cb_reg); r.error_code = ERR_HEADER;
                        have = 1'b1; phase_next = PH_DEAD;
                    end else pos_next = pos_reg + 4'd1;
                end else if (pos_reg < 4'd6) begin
                    ver_next = {ver_reg[15:0], byte_in};
                    pos_next = pos_reg + 4'd1;
                end else if (pos_reg < 4'd10) begin
                    // position minus 6: 6,7 -> 0 ; 8,9 -> 1
                    if (pos_reg[0] == 1'b0)
                        fs_next[hidx] = {8'd0, byte_in};
                    else
                        fs_next[hidx] = {byte_in, fs_reg[hidx][7:0]};
                    pos_next = pos_reg + 4'd1;
                end else if (pos_reg == 4'd10) begin
                    ps_next = byte_in; pos_next = pos_reg + 4'd1;
                end else if (pos_reg == 4'd11) begin
                    fs_next[2] = {8'd0, byte_in}; pos_next = pos_reg + 4'd1;
                end else begin
                    r = rec_new(KIND_SCREEN, cb_reg);
                    r.field_a = fs_reg[0]; r.field_b = fs_reg[1];
                    r.field_c = fs_reg[2]; r.field_d = {8'd0, byte_in};
                    r.tab_entries = ps_reg[7] ? tot : 9'd0;
                    r.small_field = {1'b0, ps_reg[6:4]} + 4'd1;
                    r.data_value = ver_reg;
                    have = 1'b1;
                    pos_next = 4'd0; rgbs_next = 2'd0;
                    left_next = ps_reg[7] ? tot : 9'd0;
                    phase_next = ps_reg[7] ? PH_GTAB : PH_BLOCK;
                end
            end
            PH_GTAB, PH_LTAB: begin
                if (rgbs_reg < 2'd2) begin
                    rgbp_next = {rgbp_reg[7:0], byte_in};
                    rgbs_next = rgbs_reg + 2'd1;
                end else begin
                    r = rec_new((phase_reg == PH_GTAB) ? KIND_GCOLOR : KIND_LCOLOR, cb_reg);
                    r.field_a = {8'd0, 8'(tot - left_reg)};
                    r.data_value = {rgbp_reg, byte_in};
                    r.tab_entries = tot;
                    have = 1'b1;
                    rgbs_next = 2'd0;
                    left_next = (left_reg != 9'd0) ? left_reg - 9'd1 : 9'd0;
                    if (left_next == 9'd0)
                        phase_next = (phase_reg == PH_GTAB) ? PH_BLOCK : PH_CODESIZE;
                end
            end
            PH_BLOCK: begin
                if (byte_in == BYTE_TRAILER) begin
                    r = rec_new(KIND_DONE, cb_reg); have = 1'b1; phase_next = PH_DONE;
                end else if (byte_in == BYTE_EXT) phase_next = PH_EXTLABEL;
                else if (byte_in == BYTE_IMAGE) begin
                    phase_next = PH_IMG; pos_next = 4'd0;
                end else begin
                    r = rec_new(KIND_ERROR, cb_reg); r.error_code = ERR_UNKNOWN;
                    have = 1'b1; phase_next = PH_DEAD;
                end
            end
            PH_EXTLABEL: begin
                if (byte_in == LBL_GCTRL) phase_next = PH_GCSIZE;
                else if (byte_in == LBL_APP) phase_next = PH_APPSIZE;
                else begin
                    cb_next = (byte_in == LBL_TEXT) ? BLK_TEXT :
                              (byte_in == LBL_CMT) ? BLK_CMT : BLK_NONE;
                    phase_next = PH_SUBLEN;
                end
            end
            PH_GCSIZE: begin
                if (byte_in != GCTRL_SIZE) begin
                    r = rec_new(KIND_ERROR, cb_reg); r.error_code = ERR_CTRLSIZE;
                    have = 1'b1; phase_next = PH_DEAD;
                end else begin
                    phase_next = PH_GCBODY; pos_next = 4'd0;
                end
            end
            PH_GCBODY: begin
                if (pos_reg == 4'd0) ps_next = byte_in;
                else if (pos_reg == 4'd1) fs_next[0] = {8'd0, byte_in};
                else if (pos_reg == 4'd2) fs_next[0] = {byte_in, fs_reg[0][7:0]};
                else begin
                    r = rec_new(KIND_GCTRL, cb_reg);
                    r.field_a = (fs_reg[0] != 16'd0) ? fs_reg[0] : 16'd10;
                    r.field_b = {8'd0, byte_in};
                    r.small_field = {1'b0, ps_reg[4:2]};
                    r.flag_bits = ps_reg[1:0];
                    have = 1'b1; cp_next = 1'b1; phase_next = PH_GCTERM;
                end
                pos_next = pos_reg + 4'd1;
            end
            PH_GCTERM: phase_next = PH_BLOCK;
            PH_APPSIZE: begin
                if (byte_in != APP_SIZE) begin
                    r = rec_new(KIND_ERROR, cb_reg); r.error_code = ERR_APPSIZE;
                    have = 1'b1; phase_next = PH_DEAD;
                end else begin
                    phase_next = PH_APPBODY; pos_next = 4'd0;
                end
            end
            PH_APPBODY: begin
                if (pos_reg < 4'd8) fs_next[idx] = {fs_reg[idx][7:0], byte_in};
                else if (pos_reg < 4'd10) rgbp_next = {rgbp_reg[7:0], byte_in};
                else begin
                    cb_next = BLK_APP;
                    r = rec_new(KIND_APPHDR, BLK_APP);
                    r.field_a = fs_reg[0]; r.field_b = fs_reg[1];
                    r.field_c = fs_reg[2]; r.field_d = fs_reg[3];
                    r.data_value = {rgbp_reg, byte_in};
                    have = 1'b1; phase_next = PH_SUBLEN;
                end
                pos_next = pos_reg + 4'd1;
            end
            PH_IMG: begin
                if (pos_reg < 4'd8) begin
                    if (pos_reg[0] == 1'b0) fs_next[idx] = {8'd0, byte_in};
                    else fs_next[idx] = {byte_in, fs_reg[idx][7:0]};
                    pos_next = pos_reg + 4'd1;
                end else begin
                    ps_next = byte_in; cb_next = BLK_IMAGE;
                    r = rec_new(KIND_IMAGE, BLK_IMAGE);
                    r.field_a = fs_reg[0]; r.field_b = fs_reg[1];
                    r.field_c = fs_reg[2]; r.field_d = fs_reg[3];
                    r.tab_entries = byte_in[7] ? tab_total(byte_in[2:0]) : 9'd0;
                    r.flag_bits = {cp_reg, byte_in[6]};
                    have = 1'b1; cp_next = 1'b0; pos_next = 4'd0; rgbs_next = 2'd0;
                    left_next = r.tab_entries;
                    phase_next = byte_in[7] ? PH_LTAB : PH_CODESIZE;
                end
            end
            PH_CODESIZE: begin
                r = rec_new(KIND_CODESIZE, cb_reg); r.data_value = {16'd0, byte_in};
                have = 1'b1; phase_next = PH_SUBLEN;
            end
            PH_SUBLEN: begin
                if (byte_in == 8'd0) begin
                    if (cb_reg != BLK_NONE) begin
                        r = rec_new(KIND_BLKEND, cb_reg); have = 1'b1;
                    end
                    cb_next = BLK_NONE; phase_next = PH_BLOCK;
                end else begin
                    sub_next = byte_in; phase_next = PH_SUBDATA;
                end
            end
            PH_SUBDATA: begin
                if (cb_reg != BLK_NONE) begin
                    r = rec_new(KIND_PAYLOAD, cb_reg); r.data_value = {16'd0, byte_in};
                    have = 1'b1;
                end
                sub_next = (sub_reg != 8'd0) ? sub_reg - 8'd1 : 8'd0;
                if (sub_next == 8'd0) phase_next = PH_SUBLEN;
            end
            default: ;
        endcase
        // result pair, with truncation flagged after the byte's own result
        res = '0;
        res.r0 = r;
        res.cnt = {1'b0, have};
        if (eos && phase_next != PH_DONE && phase_next != PH_DEAD) begin
            if (have) begin
                res.r1 = rec_new(KIND_ERROR, cb_next);
                res.r1.error_code = ERR_TRUNC;
                res.cnt = 2'd2;
            end else begin
                res.r0 = rec_new(KIND_ERROR, cb_next);
                res.r0.error_code = ERR_TRUNC;
                res.cnt = 2'd1;
            end
            phase_next = PH_DEAD;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR; pos_reg <= '0; left_reg <= '0; rgbs_reg <= '0;
            rgbp_reg <= '0; sub_reg <= '0; ps_reg <= '0; ver_reg <= '0;
            cp_reg <= 1'b0; cb_reg <= BLK_NONE;
            for (int i = 0; i < 4; i++) fs_reg[i] <= '0;
        end else if (step) begin
            phase_reg <= phase_next; pos_reg <= pos_next; left_reg <= left_next;
            rgbs_reg <= rgbs_next; rgbp_reg <= rgbp_next; sub_reg <= sub_next;
            ps_reg <= ps_next; ver_reg <= ver_next; cp_reg <= cp_next;
            cb_reg <= cb_next; fs_reg <= fs_next;
        end
    end
endmodule
`default_nettype wire

[rtl/core/gcsp_outq.sv]
`default_nettype none
module gcsp_outq import gcsp_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pair_t              in_pair,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [3:0]              m_tuser,
    output logic                    m_tlast
);
`include "gif_container_stream_parser_top_assert.svh"
    // four-entry result queue; a byte enters only when two slots are free
    rec_t       q_reg [4];
    logic       l_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;
    logic [1:0] n_in;

    assign in_ready = (cnt_reg <= 3'd2);
    assign push = in_valid && in_ready;
    assign n_in = push ? in_pair.cnt : 2'd0;
    assign m_tvalid = (cnt_reg != 3'd0);
    assign pop = m_tvalid && m_tready;
    assign m_tdata = rec_pack(q_reg[rd_reg]);
    assign m_tuser = q_reg[rd_reg].kind;
    assign m_tlast = l_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (n_in != 2'd0) begin
            q_reg[wr_reg] <= in_pair.r0;
            l_reg[wr_reg] <= (in_pair.cnt == 2'd1);
        end
        if (n_in == 2'd2) begin
            q_reg[wr_reg + 2'd1] <= in_pair.r1;
            l_reg[wr_reg + 2'd1] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= '0; wr_reg <= '0; cnt_reg <= '0;
        end else begin
            wr_reg <= wr_reg + n_in;
            rd_reg <= rd_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, n_in} - {2'b0, pop};
        end
    end

    `GCSP_ASSERT_IMPL(a_cnt_max, aclk, aresetn, 1'b1, cnt_reg <= 3'd4)
    `GCSP_ASSERT_NEXT(a_pair_fill, aclk, aresetn,
        push && in_pair.cnt == 2'd2 && !pop, cnt_reg == $past(cnt_reg) + 3'd2)
    `GCSP_ASSERT_IMPL(a_empty_novalid, aclk, aresetn, cnt_reg == 3'd0, !m_tvalid)
endmodule
`default_nettype wire

[rtl/core/gif_container_stream_parser_top.sv]
// Channel   Handshake          Payload
// input     s_tvalid/s_tready  s_tdata = byte_in, s_tlast = end_of_stream
// results   m_tvalid/m_tready  m_tuser = kind, m_tdata = result fields, m_tlast = last of byte
// A byte can be taken every cycle while s_tready is high; its results pass through the
// stage register, then the result queue, before they are offered.
// A byte is taken while the stage is empty or the four-entry queue has two slots free;
// bytes with two results therefore run at the sink's rate of one result per clock.
// aresetn is synchronous, active low; it returns the parser to the signature.
// Stalls on m_tready back up into s_tready through the queue and the stage register.
`default_nettype none
module gif_container_stream_parser_top import gcsp_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,  // [7:0] byte_in
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [2:0] block_type, [18:3] field_a, [34:19] field_b, [50:35] field_c,
    // [66:51] field_d, [75:67] tab_entries, [79:76] small_field, [81:80] flag_bits,
    // [105:82] data_value, [108:106] error_code
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [3:0]              m_tuser,  // [3:0] kind
    output logic                    m_tlast
);
    logic  step;
    pair_t pair;
    pair_t pair_reg;
    logic  pv_reg;
    logic  q_ready;

    // stage register between parser and queue
    assign s_tready = q_ready || !pv_reg;
    assign step = s_tvalid && s_tready;

    gcsp_parse u_parse (
        .aclk(aclk), .aresetn(aresetn), .step(step),
        .byte_in(s_tdata), .eos(s_tlast), .res(pair)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) pv_reg <= 1'b0;
        else if (s_tready) pv_reg <= step;
    end
    always_ff @(posedge aclk) begin
        if (s_tready) pair_reg <= pair;
    end

    gcsp_outq u_outq (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(pv_reg), .in_ready(q_ready), .in_pair(pair_reg),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );
endmodule
`default_nettype wire
